>>> rtl/touch_report_decoder_unit_macros.svh
// Assertion helpers used by the checker file.
// Both expect signals named clk and rst_n in scope.
`ifndef TOUCH_REPORT_DECODER_UNIT_MACROS_SVH
`define TOUCH_REPORT_DECODER_UNIT_MACROS_SVH

// Same-cycle implication
`define TRD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/trd_pkg.sv
package trd_pkg;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int COORD_W  = 12;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 5;
    localparam int SUM_W    = 11;
    localparam int RAW_W    = 16;
    localparam int WORD_W   = 16;
    localparam int COUNT_W  = 4;
    localparam int CFG_IDX_W = 1;

    // Scaling datapath widths
    localparam int PROD_W      = RAW_W + COORD_W;
    localparam int RECIP_W     = 29;
    localparam int RECIP_SHIFT = 39;
    localparam int QUOT_W      = 18;

    // Reciprocals: ceil(2^39 / span), exact for products below 2^28
    localparam logic [RECIP_W-1:0] RECIP_X = 29'd518637561;  // span 1060
    localparam logic [RECIP_W-1:0] RECIP_Y = 29'd229064923;  // span 2400

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'd1;

    localparam logic [COORD_W-1:0] SCREEN_WIDTH_RST  = 12'd568;
    localparam logic [COORD_W-1:0] SCREEN_HEIGHT_RST = 12'd1232;

    // Report layout
    localparam logic [POS_W-1:0] REPORT_BYTES = 5'd18;
    localparam logic [POS_W-1:0] POS_B0       = 5'd0;
    localparam logic [POS_W-1:0] POS_B2       = 5'd2;
    localparam logic [POS_W-1:0] POS_HDR_LAST = 5'd5;
    localparam logic [POS_W-1:0] POS_HDR_LO   = 5'd6;
    localparam logic [POS_W-1:0] POS_HDR_HI   = 5'd7;
    localparam logic [POS_W-1:0] POS_PT_FIRST = 5'd8;
    localparam logic [POS_W-1:0] POS_X_LO     = 5'd10;
    localparam logic [POS_W-1:0] POS_X_HI     = 5'd11;
    localparam logic [POS_W-1:0] POS_Y_LO     = 5'd12;
    localparam logic [POS_W-1:0] POS_Y_HI     = 5'd13;
    localparam logic [POS_W-1:0] POS_PT_LAST  = 5'd15;
    localparam logic [POS_W-1:0] POS_PT_LO    = 5'd16;
    localparam logic [POS_W-1:0] POS_LAST     = 5'd17;

    localparam int                 PRESS_BIT = 7;
    localparam logic [COUNT_W-1:0] COUNT_ONE = 4'd1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd10;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_HDR_SUM  = 3'd2,
        ST_COUNT    = 3'd3,
        ST_PT_SUM   = 3'd4
    } status_t;

    typedef struct packed {
        status_t            status;
        logic               pressed;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
    } result_t;

endpackage

>>> rtl/touch_report_decoder_unit.sv
// Touch report decoder. Takes one report byte per accepted word on the input
// channel, with first_of_report marking byte 0, and after byte 17 of a report
// returns one result word: status, pressed and the held screen position.
// Bytes are taken one per cycle while in_ready is high; after byte 17 is
// accepted a result passes the two-stage scaling multiplier (raw *
// resolution runs alongside the status check, then the reciprocal of the
// span) into the output buffer, which holds two result words; the input
// stalls once two results are waiting or in flight. Bytes past the end of
// a report without a new first_of_report give no result. screen_width and
// screen_height are written through cfg_write / cfg_index / cfg_data, by the
// user only while no result is in flight; the block does not enforce this.
module touch_report_decoder_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [trd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [trd_pkg::COORD_W-1:0]      cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [trd_pkg::BYTE_W-1:0]       report_byte,
    input  logic                             first_of_report,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [trd_pkg::STATUS_W-1:0]     status,
    output logic                             pressed,
    output logic [trd_pkg::COORD_W-1:0]      pos_x,
    output logic [trd_pkg::COORD_W-1:0]      pos_y
);
    import trd_pkg::*;

    // configuration
    logic [COORD_W-1:0] width_reg;
    logic [COORD_W-1:0] height_reg;

    // report tracking
    logic [POS_W-1:0]   pos_reg, pos_eff;
    logic [SUM_W-1:0]   hsum_reg, hsum_next, hsum_base;
    logic [SUM_W-1:0]   psum_reg, psum_next, psum_base;
    logic [BYTE_W-1:0]  b0_reg, b6_reg, b7_reg, b10_reg, b11_reg;
    logic [BYTE_W-1:0]  b12_reg, b13_reg, b16_reg;
    logic [COUNT_W-1:0] count_reg;

    logic               accept, take, is_final;
    logic               down;
    status_t            status_calc;

    // result pipeline
    logic               s1_v_reg, s2_v_reg;
    status_t            s1_status_reg, s2_status_reg;
    logic               s1_upd_reg, s2_upd_reg;
    logic [COORD_W-1:0] scaled_x, scaled_y;
    logic [COORD_W-1:0] held_x_reg, held_y_reg, held_x_next, held_y_next;

    // output buffer
    result_t            buf_reg [2];
    logic               wr_ptr_reg, rd_ptr_reg;
    logic [1:0]         cnt_reg;
    logic               push, pop;
    logic [2:0]         occupancy;
    result_t            push_word, head;

    // input side
    assign accept    = in_valid && in_ready;
    assign pos_eff   = first_of_report ? '0 : pos_reg;
    assign take      = accept && (pos_eff < REPORT_BYTES);
    assign is_final  = take && (pos_eff == POS_LAST);
    assign hsum_base = first_of_report ? '0 : hsum_reg;
    assign psum_base = first_of_report ? '0 : psum_reg;

    // running sums over the header and point ranges
    always_comb
    begin
        hsum_next = hsum_base;
        psum_next = psum_base;
        if (pos_eff <= POS_HDR_LAST)
            hsum_next = hsum_base + {{(SUM_W-BYTE_W){1'b0}}, report_byte};
        else if (pos_eff >= POS_PT_FIRST && pos_eff <= POS_PT_LAST)
            psum_next = psum_base + {{(SUM_W-BYTE_W){1'b0}}, report_byte};
    end

    // status checks, evaluated as the last byte arrives
    assign down = b0_reg[PRESS_BIT] && (count_reg != '0);

    always_comb
    begin
        if (b0_reg == '0)
            status_calc = ST_EMPTY;
        else if ({{(WORD_W-SUM_W){1'b0}}, hsum_reg} != {b7_reg, b6_reg})
            status_calc = ST_HDR_SUM;
        else if (count_reg > COUNT_MAX)
            status_calc = ST_COUNT;
        else if (down && count_reg == COUNT_ONE &&
                 {{(WORD_W-SUM_W){1'b0}}, psum_reg} != {report_byte, b16_reg})
            status_calc = ST_PT_SUM;
        else
            status_calc = ST_OK;
    end

    // stored report bytes
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            case (pos_eff)
                POS_B0:    b0_reg    <= report_byte;
                POS_B2:    count_reg <= report_byte[COUNT_W-1:0];
                POS_HDR_LO: b6_reg   <= report_byte;
                POS_HDR_HI: b7_reg   <= report_byte;
                POS_X_LO:  b10_reg   <= report_byte;
                POS_X_HI:  b11_reg   <= report_byte;
                POS_Y_LO:  b12_reg   <= report_byte;
                POS_Y_HI:  b13_reg   <= report_byte;
                POS_PT_LO: b16_reg   <= report_byte;
                default:   ;
            endcase
        end
    end

    // scaling units
    trd_scale u_scale_x (
        .clk    (clk),
        .raw    ({b11_reg, b10_reg}),
        .res    (width_reg),
        .recip  (RECIP_X),
        .scaled (scaled_x)
    );

    trd_scale u_scale_y (
        .clk    (clk),
        .raw    ({b13_reg, b12_reg}),
        .res    (height_reg),
        .recip  (RECIP_Y),
        .scaled (scaled_y)
    );

    // held position and result word
    assign held_x_next = s2_upd_reg ? scaled_x : held_x_reg;
    assign held_y_next = s2_upd_reg ? scaled_y : held_y_reg;

    always_comb
    begin
        push_word.status  = s2_status_reg;
        push_word.pressed = s2_upd_reg;
        push_word.pos_x   = held_x_next;
        push_word.pos_y   = held_y_next;
    end

    // output buffer control
    assign push      = s2_v_reg;
    assign pop       = out_valid && out_ready;
    assign occupancy = {2'b0, s1_v_reg} + {2'b0, s2_v_reg} + {1'b0, cnt_reg};
    assign in_ready  = occupancy < 3'd2;
    assign out_valid = cnt_reg != '0;
    assign head      = buf_reg[rd_ptr_reg];
    assign status    = head.status;
    assign pressed   = head.pressed;
    assign pos_x     = head.pos_x;
    assign pos_y     = head.pos_y;

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_ptr_reg] <= push_word;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= SCREEN_WIDTH_RST;
            height_reg    <= SCREEN_HEIGHT_RST;
            pos_reg       <= '0;
            hsum_reg      <= '0;
            psum_reg      <= '0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s1_status_reg <= ST_OK;
            s2_status_reg <= ST_OK;
            s1_upd_reg    <= 1'b0;
            s2_upd_reg    <= 1'b0;
            held_x_reg    <= '0;
            held_y_reg    <= '0;
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            // configuration writes
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                    CFG_SCREEN_HEIGHT: height_reg <= cfg_data;
                    default:           ;
                endcase
            end

            // position and sums; a flag past the end still restarts
            if (take)
            begin
                pos_reg  <= pos_eff + 5'd1;
                hsum_reg <= hsum_next;
                psum_reg <= psum_next;
            end
            else if (accept)
            begin
                pos_reg  <= pos_eff;
                hsum_reg <= hsum_base;
                psum_reg <= psum_base;
            end

            // result pipeline
            s1_v_reg      <= is_final;
            s1_status_reg <= status_calc;
            s1_upd_reg    <= (status_calc == ST_OK) && down;
            s2_v_reg      <= s1_v_reg;
            s2_status_reg <= s1_status_reg;
            s2_upd_reg    <= s1_v_reg && s1_upd_reg;

            if (push)
            begin
                held_x_reg <= held_x_next;
                held_y_reg <= held_y_next;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

>>> rtl/trd_scale.sv
module trd_scale (
    input  logic                          clk,
    input  logic [trd_pkg::RAW_W-1:0]     raw,
    input  logic [trd_pkg::COORD_W-1:0]   res,
    input  logic [trd_pkg::RECIP_W-1:0]   recip,
    output logic [trd_pkg::COORD_W-1:0]   scaled
);
    import trd_pkg::*;

    logic [PROD_W-1:0]           prod_reg;
    logic [COORD_W-1:0]          res_a_reg;
    logic [QUOT_W-1:0]           quot_reg;
    logic [COORD_W-1:0]          res_b_reg;
    logic [PROD_W+RECIP_W-1:0]   full_prod;

    // raw * res, then divide by the span through the reciprocal
    assign full_prod = prod_reg * recip;

    always_ff @(posedge clk)
    begin
        prod_reg  <= raw * res;
        res_a_reg <= res;
        quot_reg  <= full_prod[RECIP_SHIFT +: QUOT_W];
        res_b_reg <= res_a_reg;
    end

    // clamp to res-1; zero resolution scales to 0
    always_comb
    begin
        if (res_b_reg == '0)
            scaled = '0;
        else if (quot_reg < {{(QUOT_W-COORD_W){1'b0}}, res_b_reg})
            scaled = quot_reg[COORD_W-1:0];
        else
            scaled = res_b_reg - 12'd1;
    end

endmodule

>>> rtl/trd_checker.sv
`include "touch_report_decoder_unit_macros.svh"

module trd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             cfg_write,
    input logic [trd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input logic [trd_pkg::COORD_W-1:0]      cfg_data,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic [trd_pkg::BYTE_W-1:0]       report_byte,
    input logic                             first_of_report,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [trd_pkg::STATUS_W-1:0]     status,
    input logic                             pressed,
    input logic [trd_pkg::COORD_W-1:0]      pos_x,
    input logic [trd_pkg::COORD_W-1:0]      pos_y
);
    import trd_pkg::*;

    // a stalled result word holds
    `TRD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(status) && $stable(pressed) && $stable(pos_x) && $stable(pos_y),
        "result word changed while stalled")

    // pressed only with a clean report
    `TRD_ASSERT_NOW(a_pressed_ok, out_valid && pressed, status == ST_OK,
        "pressed reported with an error status")

    // status codes stay within the defined set
    `TRD_ASSERT_NOW(a_status_code, out_valid, status <= ST_PT_SUM,
        "undefined status code")

    // input stalls only behind a waiting result
    `TRD_ASSERT_NOW(a_stall_cause, !in_ready, out_valid,
        "input stalled with no result waiting")

endmodule

bind touch_report_decoder_unit trd_checker u_trd_checker (.*);

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import trd_pkg::*;

    localparam int X_SPAN = 1060;
    localparam int Y_SPAN = 2400;
    localparam int PHASES = 6;
    localparam int REPORTS_PER_PHASE = 2;
    localparam int SETTLE_CYCLES = 8;

    // One directed report: how it is built, how much of it is sent, and
    // optionally the result written out by hand.
    typedef struct packed {
        logic [7:0]  head;
        logic [7:0]  cnt;
        logic [15:0] rx;
        logic [15:0] ry;
        logic        hdr_ok;
        logic        pt_ok;
        logic        flag;
        logic [4:0]  len;
        logic [1:0]  tail;
        logic        typed;
        result_t     want;
    } plan_row_t;

    localparam int PLAN_ROWS = 16;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COORD_W-1:0]   cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [BYTE_W-1:0]    report_byte = '0;
    logic                 first_of_report = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic                 pressed;
    logic [COORD_W-1:0]   pos_x;
    logic [COORD_W-1:0]   pos_y;

    touch_report_decoder_unit uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .report_byte     (report_byte),
        .first_of_report (first_of_report),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .pressed         (pressed),
        .pos_x           (pos_x),
        .pos_y           (pos_y)
    );

    always #6 clk = ~clk;

    // Decoder state as the block should hold it
    logic [POS_W-1:0]   byte_idx = '0;
    logic [15:0]        hdr_acc = '0;
    logic [15:0]        pt_acc = '0;
    logic [7:0]         report_copy [18];
    logic [COORD_W-1:0] held_px = '0;
    logic [COORD_W-1:0] held_py = '0;
    logic [COORD_W-1:0] screen_w = SCREEN_WIDTH_RST;
    logic [COORD_W-1:0] screen_h = SCREEN_HEIGHT_RST;

    result_t     pending_reports [$];
    bit          typed_armed = 1'b0;
    result_t     typed_result;
    bit          tx_idle = 1'b0;
    bit          rx_idle = 1'b0;
    int          stall_left = 0;
    int unsigned mismatches = 0;
    int unsigned words_in = 0;
    int unsigned reports_seen = 0;
    int unsigned status_hits [5] = '{0, 0, 0, 0, 0};

    logic [7:0]   frame [18];
    plan_row_t    plan [PLAN_ROWS];
    logic [11:0]  sweep_w [PHASES];
    logic [11:0]  sweep_h [PHASES];

    // raw * res / span, rounded down and held below res
    function automatic logic [COORD_W-1:0] fit_axis(input logic [15:0] raw,
                                                    input logic [COORD_W-1:0] res,
                                                    input int unsigned span);
        int unsigned v;
        if (res == '0)
            return '0;
        v = (32'(raw) * 32'(res)) / span;
        return (v < 32'(res)) ? v[COORD_W-1:0] : res - 1'b1;
    endfunction

    // Take one report byte; returns 1 with the decoded result after byte 17
    function automatic bit decode_byte(input logic [7:0] b, input logic first,
                                       output result_t r);
        logic [3:0] fingers;
        logic       down;
        status_t    st;
        r = '0;
        if (first)
        begin
            byte_idx = '0;
            hdr_acc = '0;
            pt_acc = '0;
        end
        // past the end and no new start: ignored
        if (byte_idx >= REPORT_BYTES)
            return 1'b0;
        report_copy[byte_idx] = b;
        if (byte_idx <= POS_HDR_LAST)
            hdr_acc = hdr_acc + 16'(b);
        else if (byte_idx >= POS_PT_FIRST && byte_idx <= POS_PT_LAST)
            pt_acc = pt_acc + 16'(b);
        byte_idx = byte_idx + 1'b1;
        if (byte_idx != REPORT_BYTES)
            return 1'b0;

        fingers = report_copy[POS_B2][3:0];
        down = report_copy[POS_B0][PRESS_BIT] && (fingers != '0);
        if (report_copy[POS_B0] == 8'h00)
            st = ST_EMPTY;
        else if (hdr_acc != {report_copy[POS_HDR_HI], report_copy[POS_HDR_LO]})
            st = ST_HDR_SUM;
        else if (fingers > COUNT_MAX)
            st = ST_COUNT;
        else if (down && fingers == COUNT_ONE &&
                 pt_acc != {report_copy[POS_LAST], report_copy[POS_PT_LO]})
            st = ST_PT_SUM;
        else
            st = ST_OK;

        if (st == ST_OK && down)
        begin
            held_px = fit_axis({report_copy[POS_X_HI], report_copy[POS_X_LO]},
                               screen_w, X_SPAN);
            held_py = fit_axis({report_copy[POS_Y_HI], report_copy[POS_Y_LO]},
                               screen_h, Y_SPAN);
        end
        r.status = st;
        r.pressed = (st == ST_OK) && down;
        r.pos_x = held_px;
        r.pos_y = held_py;
        return 1'b1;
    endfunction

    // Fill frame with a report; bad sums get a nonzero offset
    function automatic void build_frame(input logic [7:0] head, input logic [7:0] cnt,
                                        input logic [15:0] rx, input logic [15:0] ry,
                                        input bit hdr_ok, input bit pt_ok);
        logic [15:0] sum;
        for (int i = 0; i < 18; i++)
            frame[i] = 8'($urandom);
        frame[0] = head;
        frame[2] = cnt;
        frame[10] = rx[7:0];
        frame[11] = rx[15:8];
        frame[12] = ry[7:0];
        frame[13] = ry[15:8];
        sum = '0;
        for (int i = 0; i <= 5; i++)
            sum = sum + 16'(frame[i]);
        if (!hdr_ok)
            sum = sum + 16'($urandom_range(1, 65535));
        frame[6] = sum[7:0];
        frame[7] = sum[15:8];
        sum = '0;
        for (int i = 8; i <= 15; i++)
            sum = sum + 16'(frame[i]);
        if (!pt_ok)
            sum = sum + 16'($urandom_range(1, 65535));
        frame[16] = sum[7:0];
        frame[17] = sum[15:8];
    endfunction

    function automatic logic [15:0] pick_raw(input int span);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        if (r < 6)
            return 16'($urandom_range(0, span + 10));
        return 16'($urandom);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input logic [7:0] b, input logic first);
        if (tx_idle && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid <= 1'b1;
        report_byte <= b;
        first_of_report <= first;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_frame(input logic flag, input int len);
        for (int i = 0; i < len; i++)
            send_word(frame[i], (i == 0) ? flag : 1'b0);
    endtask

    // Bytes past the end of a report, no start flag
    task automatic send_tail(input int n);
        for (int i = 0; i < n; i++)
            send_word(8'($urandom), 1'b0);
    endtask

    // Stop sending and wait until every result is back and the pipe is quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_screen(input logic [11:0] w, input logic [11:0] h);
        cfg_write <= 1'b1;
        cfg_index <= CFG_SCREEN_WIDTH;
        cfg_data <= w;
        @(negedge clk);
        cfg_index <= CFG_SCREEN_HEIGHT;
        cfg_data <= h;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // One random report: mostly well formed, some truncated or garbage
    task automatic random_report(output bit complete);
        logic [7:0]  head;
        logic [3:0]  nib;
        int          pick;
        pick = $urandom_range(0, 99);
        complete = 1'b1;
        if (pick < 8)
        begin
            // cut short, the next report restarts with the flag
            build_frame(8'h81, 8'h01, pick_raw(X_SPAN), pick_raw(Y_SPAN), 1'b1, 1'b1);
            send_frame(1'b1, $urandom_range(1, 17));
            complete = 1'b0;
        end
        else if (pick < 14)
        begin
            for (int i = 0; i < 18; i++)
                frame[i] = 8'($urandom);
            send_frame(1'b1, 18);
        end
        else
        begin
            head = {($urandom_range(0, 9) != 0), 7'($urandom)};
            if ($urandom_range(0, 19) == 0)
                head = 8'h00;
            pick = $urandom_range(0, 19);
            if (pick < 11)
                nib = 4'd1;
            else if (pick < 16)
                nib = 4'($urandom_range(0, 10));
            else
                nib = 4'($urandom_range(11, 15));
            build_frame(head, {4'($urandom), nib}, pick_raw(X_SPAN), pick_raw(Y_SPAN),
                        $urandom_range(0, 9) != 0, $urandom_range(0, 6) != 0);
            send_frame(1'b1, 18);
            if ($urandom_range(0, 9) == 0)
                send_tail($urandom_range(1, 3));
        end
    endtask

    // Receiver stalls in bursts while rx_idle is set
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (rx_idle && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 4);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Track register writes and accepted bytes
    always @(posedge clk)
    begin : take_input
        result_t got;
        if (rst_n)
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_SCREEN_WIDTH:  screen_w = cfg_data;
                    CFG_SCREEN_HEIGHT: screen_h = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                words_in = words_in + 1;
                if (decode_byte(report_byte, first_of_report, got))
                begin
                    pending_reports.push_back(typed_armed ? typed_result : got);
                    typed_armed = 1'b0;
                end
            end
        end
    end

    // Compare each result word against the oldest pending one
    always @(posedge clk)
    begin : take_result
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                mismatches = mismatches + 1;
                $display("%0t: unexpected result: expected none, got status %0d pressed %0b x %0d y %0d",
                         $time, status, pressed, pos_x, pos_y);
            end
            else
            begin
                want = pending_reports.pop_front();
                reports_seen = reports_seen + 1;
                status_hits[want.status] = status_hits[want.status] + 1;
                if ({status, pressed, pos_x, pos_y} !== want)
                begin
                    mismatches = mismatches + 1;
                    $display("%0t: mismatch: expected status %0d pressed %0b x %0d y %0d, got status %0d pressed %0b x %0d y %0d",
                             $time, want.status, want.pressed, want.pos_x, want.pos_y,
                             status, pressed, pos_x, pos_y);
                end
            end
        end
    end

    initial
    begin : run
        bit complete;
        int done;

        // head, count byte, raw x, raw y, header ok, point ok, flag, length, tail,
        // typed, result (default screen 568 x 1232)
        plan = '{
            // empty report right after reset, no start flag
            '{8'h00, 8'h01, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b0, 5'd18, 2'd0, 1'b1,
              '{ST_EMPTY, 1'b0, 12'd0, 12'd0}},
            '{8'h81, 8'h01, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b1, 5'd18, 2'd0, 1'b1,
              '{ST_HDR_SUM, 1'b0, 12'd0, 12'd0}},
            // header sum wins over a bad count
            '{8'h81, 8'h0F, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, 5'd18, 2'd0, 1'b1,
              '{ST_HDR_SUM, 1'b0, 12'd0, 12'd0}},
            '{8'h81, 8'h0B, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1, 5'd18, 2'd0, 1'b1,
              '{ST_COUNT, 1'b0, 12'd0, 12'd0}},
            '{8'h80, 8'hFF, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b1, 5'd18, 2'd0, 1'b1,
              '{ST_COUNT, 1'b0, 12'd0, 12'd0}},
            '{8'h81, 8'h01, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b1, 5'd18, 2'd0, 1'b1,
              '{ST_PT_SUM, 1'b0, 12'd0, 12'd0}},
            '{8'h80, 8'h01, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1, 5'd18, 2'd0, 1'b1,
              '{ST_OK, 1'b1, 12'd0, 12'd0}},
            // full-scale raw values clamp to resolution - 1
            '{8'hFF, 8'hF1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 5'd18, 2'd0, 1'b1,
              '{ST_OK, 1'b1, 12'd567, 12'd1231}},
            // error leaves the held position alone
            '{8'h81, 8'h01, 16'd530, 16'd1200, 1'b0, 1'b1, 1'b1, 5'd18, 2'd0, 1'b1,
              '{ST_HDR_SUM, 1'b0, 12'd567, 12'd1231}},
            // no press bit, then no fingers: point sum not looked at
            '{8'h01, 8'h01, 16'd100, 16'd100, 1'b1, 1'b1, 1'b1, 5'd18, 2'd0, 1'b1,
              '{ST_OK, 1'b0, 12'd567, 12'd1231}},
            '{8'h80, 8'h00, 16'd100, 16'd100, 1'b1, 1'b0, 1'b1, 5'd18, 2'd0, 1'b1,
              '{ST_OK, 1'b0, 12'd567, 12'd1231}},
            // empty wins over a bad header sum
            '{8'h00, 8'h01, 16'd100, 16'd100, 1'b0, 1'b1, 1'b1, 5'd18, 2'd0, 1'b1,
              '{ST_EMPTY, 1'b0, 12'd567, 12'd1231}},
            // two fingers, bad point sum ignored
            '{8'h82, 8'h02, 16'd530, 16'd1200, 1'b1, 1'b0, 1'b1, 5'd18, 2'd0, 1'b0,
              '{ST_OK, 1'b0, 12'd0, 12'd0}},
            // dropped by a restart in the middle
            '{8'h81, 8'h01, 16'd700, 16'd700, 1'b1, 1'b1, 1'b1, 5'd7, 2'd0, 1'b0,
              '{ST_OK, 1'b0, 12'd0, 12'd0}},
            // count at its limit, then stray bytes past the end
            '{8'h81, 8'h0A, 16'd1060, 16'd2400, 1'b1, 1'b1, 1'b1, 5'd18, 2'd3, 1'b0,
              '{ST_OK, 1'b0, 12'd0, 12'd0}},
            '{8'h81, 8'h01, 16'd1059, 16'd2399, 1'b1, 1'b1, 1'b1, 5'd18, 2'd0, 1'b0,
              '{ST_OK, 1'b0, 12'd0, 12'd0}}
        };

        // screen sweep: extremes, zero, mixed, random, back to default
        sweep_w = '{12'd4095, 12'd1, 12'd0, 12'd4095, 12'($urandom_range(1, 4095)),
                    SCREEN_WIDTH_RST};
        sweep_h = '{12'd4095, 12'd1, 12'd0, 12'd1, 12'($urandom_range(1, 4095)),
                    SCREEN_HEIGHT_RST};

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed reports under the reset resolution
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        for (int k = 0; k < PLAN_ROWS; k++)
        begin
            typed_armed = plan[k].typed;
            typed_result = plan[k].want;
            build_frame(plan[k].head, plan[k].cnt, plan[k].rx, plan[k].ry,
                        plan[k].hdr_ok, plan[k].pt_ok);
            send_frame(plan[k].flag, int'(plan[k].len));
            send_tail(int'(plan[k].tail));
        end

        // random reports, one screen setting per phase; last phase runs flat out
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            set_screen(sweep_w[p], sweep_h[p]);
            tx_idle = (p != PHASES - 1) && (p % 3 != 1);
            rx_idle = (p != PHASES - 1) && (p % 3 != 2);
            done = 0;
            while (done < REPORTS_PER_PHASE)
            begin
                random_report(complete);
                if (complete)
                    done = done + 1;
            end
        end
        settle();

        $display("Ran %0d report bytes and %0d results over %0d screen settings",
                 words_in, reports_seen, PHASES + 1);
        $display("Status mix: ok %0d, empty %0d, header sum %0d, count %0d, point sum %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4]);
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timed out with %0d results still pending", pending_reports.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/trd_pkg.sv
rtl/trd_scale.sv
rtl/touch_report_decoder_unit.sv
rtl/trd_checker.sv
verif/tb.sv
